// File: rtl/lpc_pkg.sv
package lpc_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;
	localparam int ATAN_IDX_W       = 5;
	localparam int ATAN_W           = 30;

	localparam int RANGE_W = 16;
	localparam int ANGLE_W = 32;
	localparam int COORD_W = 17;
	localparam int X0_W    = 46;  // 16-bit range times Q30 gain
	localparam int ACC_W   = 48;  // rotated vector, Q30
	localparam int Z_W     = 34;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [29:0] GAIN_Q30 = 30'd652032874;
	localparam logic [15:0] MAX_RANGE_RST = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_ANGLE = 8'd0,
		REG_ANGLE_STEP  = 8'd1,
		REG_MIN_RANGE   = 8'd2,
		REG_MAX_RANGE   = 8'd3
	} reg_idx_t;

	typedef struct packed {
		logic                  valid;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// one accepted point waiting for rotation
	typedef struct packed {
		logic                      flip;
		logic signed [ANGLE_W-1:0] z;
		logic [X0_W-1:0]           x0;
	} work_item_t;

	function automatic logic [ATAN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		case (idx)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/lpc_queue.sv
module lpc_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  lpc_pkg::work_item_t     wdata,
	output logic                    full,
	input  logic                    pop,
	output lpc_pkg::work_item_t     rdata,
	output logic                    empty
);

	localparam int DEPTH = lpc_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lpc_pkg::work_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/lpc_front.sv
module lpc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lpc_pkg::cfg_wr_t                    cfg_wr,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [lpc_pkg::RANGE_W-1:0]         range_mm,
	input  logic                                scan_start,
	output logic                                push,
	output lpc_pkg::work_item_t                 push_item,
	input  logic                                queue_full
);

	logic [lpc_pkg::ANGLE_W-1:0] start_angle_q;
	logic [lpc_pkg::ANGLE_W-1:0] angle_step_q;
	logic [lpc_pkg::RANGE_W-1:0] min_range_q;
	logic [lpc_pkg::RANGE_W-1:0] max_range_q;
	logic [lpc_pkg::ANGLE_W-1:0] phase_acc_q;

	logic                        accept;
	logic [lpc_pkg::ANGLE_W-1:0] angle;
	logic                        in_window;
	logic                        flip;

	assign in_stall  = queue_full;
	assign accept    = in_valid && !queue_full;
	assign angle     = scan_start ? start_angle_q : phase_acc_q;
	assign in_window = (range_mm != '0) && (range_mm >= min_range_q)
		&& (range_mm <= max_range_q);

	// second and third quadrant: rotate by half a turn, negate the result
	assign flip = angle[31] ^ angle[30];

	assign push             = accept && in_window;
	assign push_item.flip   = flip;
	assign push_item.z      = $signed({angle[31] ^ flip, angle[30:0]});
	assign push_item.x0     = lpc_pkg::X0_W'(range_mm) * lpc_pkg::X0_W'(lpc_pkg::GAIN_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= '0;
			angle_step_q  <= '0;
			min_range_q   <= '0;
			max_range_q   <= lpc_pkg::MAX_RANGE_RST;
			phase_acc_q   <= '0;
		end else begin
			if (cfg_wr.valid) begin
				case (cfg_wr.index)
					lpc_pkg::REG_START_ANGLE: start_angle_q <= cfg_wr.data;
					lpc_pkg::REG_ANGLE_STEP:  angle_step_q  <= cfg_wr.data;
					lpc_pkg::REG_MIN_RANGE:   min_range_q   <= cfg_wr.data[15:0];
					lpc_pkg::REG_MAX_RANGE:   max_range_q   <= cfg_wr.data[15:0];
					default: ;
				endcase
			end
			if (accept) begin
				phase_acc_q <= angle + angle_step_q;
			end
		end
	end

endmodule

// File: rtl/lpc_back.sv
module lpc_back #(
	parameter int CORDIC_STEPS = lpc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                queue_empty,
	input  lpc_pkg::work_item_t                 pop_item,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lpc_pkg::COORD_W-1:0]  x_mm,
	output logic signed [lpc_pkg::COORD_W-1:0]  y_mm
);

	localparam int STEPS = (CORDIC_STEPS > lpc_pkg::ATAN_ENTRIES) ?
		lpc_pkg::ATAN_ENTRIES : CORDIC_STEPS;
	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int ACC_W = lpc_pkg::ACC_W;
	localparam int Z_W   = lpc_pkg::Z_W;
	localparam int RND_W = ACC_W - 30;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ROT  = 3'b010,
		ST_RND  = 3'b100
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [ACC_W-1:0]   x_q;
	logic signed [ACC_W-1:0]   y_q;
	logic signed [Z_W-1:0]     z_q;
	logic                      flip_q;
	logic                      out_valid_q;
	logic signed [lpc_pkg::COORD_W-1:0] x_out_q;
	logic signed [lpc_pkg::COORD_W-1:0] y_out_q;

	logic signed [ACC_W-1:0]   dx;
	logic signed [ACC_W-1:0]   dy;
	logic signed [Z_W-1:0]     atan;
	logic                      out_free;
	logic signed [lpc_pkg::COORD_W-1:0] x_fin;
	logic signed [lpc_pkg::COORD_W-1:0] y_fin;

	assign pop       = (state_q == ST_IDLE) && !queue_empty;
	assign dx        = y_q >>> cnt_q;
	assign dy        = x_q >>> cnt_q;
	assign atan      = $signed({{(Z_W - lpc_pkg::ATAN_W){1'b0}},
		lpc_pkg::atan_turn(lpc_pkg::ATAN_IDX_W'(cnt_q))});
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign x_mm      = x_out_q;
	assign y_mm      = y_out_q;

	// round half up from Q30, clamp to +-65535, then undo the fold
	function automatic logic signed [lpc_pkg::COORD_W-1:0] finish(
		input logic signed [ACC_W-1:0] v,
		input logic                    neg
	);
		logic signed [ACC_W-1:0] vr;
		logic signed [RND_W-1:0] q;
		logic signed [lpc_pkg::COORD_W-1:0] s;
		vr = v + ACC_W'(64'sd536870912);
		q  = vr[ACC_W-1:30];
		if (q > RND_W'(65535)) begin
			s = 17'sd65535;
		end else if (q < -RND_W'(65535)) begin
			s = -17'sd65535;
		end else begin
			s = q[lpc_pkg::COORD_W-1:0];
		end
		return neg ? -s : s;
	endfunction

	assign x_fin = finish(x_q, flip_q);
	assign y_fin = finish(y_q, flip_q);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q    <= $signed({{(ACC_W - lpc_pkg::X0_W){1'b0}}, pop_item.x0});
				y_q    <= '0;
				z_q    <= Z_W'(pop_item.z);
				flip_q <= pop_item.flip;
			end
			ST_ROT: begin
				if (!z_q[Z_W-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan;
				end
			end
			default: ;
		endcase
		if (state_q == ST_RND && out_free) begin
			x_out_q <= x_fin;
			y_out_q <= y_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (!queue_empty) begin
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					if (cnt_q == CNT_W'(STEPS - 1)) begin
						state_q <= ST_RND;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_RND && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/lidar_polar_to_cartesian.sv
// channel  dir  valid      stall / ready   payload
// in       in   in_valid   in_stall        range_mm[15:0], scan_start
// out      out  out_valid  out_stall       x_mm[16:0], y_mm[16:0] (signed)
// cfg      in   cfg_valid  cfg_ready       cfg_index[7:0], cfg_data[31:0]
//
// An input item is taken whenever the front is not stalling; the front stalls only
// when the two-entry queue is full. Each point passes through the shared CORDIC
// rotator (load, one iteration per cycle, round), and the rotator takes a new point
// only once the last one is rounded into the output register; rejected samples
// never enter the queue. Reset clears config to its defaults, the phase and
// the queue. A stalled result sits in the output register while the next one
// rotates.
module lidar_polar_to_cartesian #(
	parameter int CORDIC_STEPS = lpc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [lpc_pkg::RANGE_W-1:0]         range_mm,
	input  logic                                scan_start,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lpc_pkg::COORD_W-1:0]  x_mm,
	output logic signed [lpc_pkg::COORD_W-1:0]  y_mm,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	lpc_pkg::cfg_wr_t    cfg_wr;
	lpc_pkg::work_item_t push_item;
	lpc_pkg::work_item_t pop_item;
	logic push;
	logic pop;
	logic queue_full;
	logic queue_empty;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	lpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.range_mm   (range_mm),
		.scan_start (scan_start),
		.push       (push),
		.push_item  (push_item),
		.queue_full (queue_full)
	);

	lpc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_item),
		.full   (queue_full),
		.pop    (pop),
		.rdata  (pop_item),
		.empty  (queue_empty)
	);

	lpc_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.pop_item    (pop_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.x_mm        (x_mm),
		.y_mm        (y_mm)
	);

endmodule

// File: rtl/lpc_checker.sv
module lpc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [lpc_pkg::COORD_W-1:0]  x_mm,
	input logic signed [lpc_pkg::COORD_W-1:0]  y_mm,
	input logic                                cfg_ready
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(x_mm) && $stable(y_mm))
		else $error("result changed while stalled");

	// saturation keeps the most negative code out
	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> x_mm != 17'h10000 && y_mm != 17'h10000)
		else $error("coordinate outside +-65535");

	// reset clears the output register
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result shown during reset");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind lidar_polar_to_cartesian lpc_checker u_lpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.x_mm      (x_mm),
	.y_mm      (y_mm),
	.cfg_ready (cfg_ready)
);

// File: verif/lidar_polar_to_cartesian_tb.sv
module lidar_polar_to_cartesian_tb;

	import lpc_pkg::*;

	localparam int ROT_STEPS = (CORDIC_STEPS_DEF > 24) ? 24 : CORDIC_STEPS_DEF;
	localparam longint ROT_GAIN = 64'sd652032874;
	localparam longint ROUND_HALF = 64'sd536870912;
	localparam int SETTLE_CYCLES = CORDIC_STEPS_DEF + 8;
	localparam int LONG_HOLD = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hA5;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [RANGE_W-1:0] range_mm = '0;
	logic scan_start = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [COORD_W-1:0] x_mm;
	logic signed [COORD_W-1:0] y_mm;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow of the block's registers and beam phase
	logic [31:0] start_ang = '0;
	logic [31:0] step_ang = '0;
	logic [15:0] win_lo = '0;
	logic [15:0] win_hi = 16'hFFFF;
	logic [31:0] beam_phase = '0;

	point_t expected_pts[$];
	point_t want;

	int bad_points = 0;
	int points_ok = 0;
	int samples_sent = 0;
	int reg_writes = 0;
	int scans_run = 0;
	int quiet_cycles = 0;
	bit idle_on = 1'b1;

	// receiver hold-off requests, bumped by the test sequence
	int hold_ask = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int stall_left = 0;
	int free_left = 0;

	lidar_polar_to_cartesian DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.range_mm(range_mm),
		.scan_start(scan_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.x_mm(x_mm),
		.y_mm(y_mm),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint atan_of_step(input int i);
		case (i)
			0: return 536870912;
			1: return 316933406;
			2: return 167458907;
			3: return 85004756;
			4: return 42667331;
			5: return 21354465;
			6: return 10679838;
			7: return 5340245;
			8: return 2670163;
			9: return 1335087;
			10: return 667544;
			11: return 333772;
			12: return 166886;
			13: return 83443;
			14: return 41722;
			15: return 20861;
			16: return 10430;
			17: return 5215;
			18: return 2608;
			19: return 1304;
			20: return 652;
			21: return 326;
			22: return 163;
			23: return 81;
			default: return 0;
		endcase
	endfunction

	function automatic longint round_to_mm(input longint v);
		longint r;
		r = (v + ROUND_HALF) >>> 30;
		if (r > 65535)
			r = 65535;
		if (r < -65535)
			r = -65535;
		return r;
	endfunction

	function automatic point_t rotate_point(input logic [15:0] r, input logic [31:0] ang);
		logic flip;
		logic [31:0] a;
		longint z, x, y, dx, dy, xr, yr;
		point_t p;
		flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
		a = flip ? ang - 32'h8000_0000 : ang;
		z = longint'($signed(a));
		x = longint'({48'd0, r}) * ROT_GAIN;
		y = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - atan_of_step(i);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + atan_of_step(i);
			end
		end
		xr = round_to_mm(x);
		yr = round_to_mm(y);
		if (flip) begin
			xr = -xr;
			yr = -yr;
		end
		p.x = xr[COORD_W-1:0];
		p.y = yr[COORD_W-1:0];
		return p;
	endfunction

	function automatic void track_sample(input logic [15:0] r, input logic first);
		logic [31:0] a;
		a = first ? start_ang : beam_phase;
		beam_phase = a + step_ang;
		if (r != 0 && r >= win_lo && r <= win_hi)
			expected_pts.insert(expected_pts.size(), rotate_point(r, a));
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		case (idx)
			REG_START_ANGLE: start_ang = data;
			REG_ANGLE_STEP: step_ang = data;
			REG_MIN_RANGE: win_lo = data[15:0];
			REG_MAX_RANGE: win_hi = data[15:0];
			default: ;
		endcase
	endfunction

	function automatic logic [15:0] pick_range(input logic [15:0] lo, input logic [15:0] hi);
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'($urandom());
			2: return $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
			3: return lo - 16'd1;
			4: return hi + 16'd1;
			default: return (lo <= hi) ? 16'($urandom_range(hi, lo)) : 16'($urandom());
		endcase
	endfunction

	// item stays offered until taken; valid is left high for a following item
	task automatic send_sample(input logic [15:0] r, input logic first);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		range_mm <= r;
		scan_start <= first;
		do @(posedge clk); while (in_stall);
		track_sample(r, first);
		samples_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		reg_writes++;
	endtask

	task automatic cfg_release();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every point is out, then let the block settle before the next step
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_pts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [31:0] st, input logic [31:0] stp,
			input logic [31:0] lo, input logic [31:0] hi);
		drain();
		write_reg(REG_START_ANGLE, st);
		write_reg(REG_ANGLE_STEP, stp);
		write_reg(REG_MIN_RANGE, lo);
		write_reg(REG_MAX_RANGE, hi);
		cfg_release();
	endtask

	task automatic test_reset_defaults();
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'd0, 1'b0);
		send_sample(16'd1, 1'b0);
		drain();
	endtask

	// quadrant boundaries and the folding edges on both sides of them
	task automatic test_quadrant_edges();
		program_regs(32'h0, 32'h4000_0000, 32'd0, 32'd65535);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		program_regs(32'h3FFF_FFFF, 32'h4000_0000, 32'd0, 32'd65535);
		send_sample(16'd1, 1'b1);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'd40000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		program_regs(32'h0, 32'hFFFF_FFFF, 32'd0, 32'd65535);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		drain();
	endtask

	// window edges, empty window, ignored upper data bits, unmapped index
	task automatic test_range_window();
		program_regs(32'h2000_0000, 32'h0100_0000, {16'hDEAD, 16'd100}, {16'hBEEF, 16'd200});
		send_sample(16'd99, 1'b1);
		send_sample(16'd100, 1'b0);
		send_sample(16'd200, 1'b0);
		send_sample(16'd201, 1'b0);
		send_sample(16'd0, 1'b0);
		program_regs(32'hC000_0000, 32'h0800_0000, 32'd500, 32'd400);
		send_sample(16'd450, 1'b1);
		send_sample(16'd500, 1'b0);
		drain();
		write_reg(REG_UNMAPPED, 32'h0000_FFFF);
		cfg_release();
		send_sample(16'd450, 1'b0);
		program_regs(32'h9000_0000, 32'h1234_5678, 32'd65535, 32'd65535);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'hFFFE, 1'b0);
		drain();
	endtask

	// receiver holds off while points keep coming, so the input side must stall
	task automatic test_output_hold();
		program_regs(32'h1000_0000, 32'h0123_4567, 32'd0, 32'd65535);
		hold_ask <= hold_ask + 1;
		for (int i = 0; i < 24; i++)
			send_sample(16'($urandom_range(1, 65535)), i == 0);
		drain();
	endtask

	task automatic test_random_scans(input int n_items);
		int sent;
		int len;
		logic [15:0] lo, hi;
		logic [31:0] st, stp;
		sent = 0;
		while (sent < n_items) begin
			st = $urandom();
			case ($urandom_range(0, 7))
				0: stp = $urandom();
				1: stp = 32'h0;
				2: stp = 32'hFFFF_FFFF;
				3: stp = 32'h8000_0000;
				default: stp = 32'(64'h1_0000_0000 / $urandom_range(8, 720));
			endcase
			case ($urandom_range(0, 5))
				0: begin
					lo = 16'd0;
					hi = 16'hFFFF;
				end
				1: begin
					lo = 16'($urandom());
					hi = 16'($urandom());
				end
				2: begin
					lo = 16'($urandom_range(30000, 65535));
					hi = 16'($urandom_range(0, 29999));
				end
				3: begin
					lo = 16'($urandom());
					hi = lo;
				end
				default: begin
					lo = 16'($urandom_range(0, 800));
					hi = 16'($urandom_range(2000, 65535));
				end
			endcase
			program_regs(st, stp, {16'($urandom()), lo}, {16'($urandom()), hi});
			len = $urandom_range(10, 60);
			// stray scan starts mid-scan act as noise
			for (int i = 0; i < len; i++)
				send_sample(pick_range(lo, hi), i == 0 || $urandom_range(0, 39) == 0);
			sent += len;
			scans_run++;
		end
	endtask

	always @(posedge clk) begin
		if (out_valid === 1'b1 && !out_stall) begin
			if (expected_pts.size() == 0) begin
				bad_points++;
				if (bad_points <= 10)
					$display("unexpected point x=%0d y=%0d", x_mm, y_mm);
			end else begin
				want = expected_pts.pop_front();
				if (x_mm !== want.x || y_mm !== want.y) begin
					bad_points++;
					if (bad_points <= 10)
						$display("point mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
							want.x, want.y, x_mm, y_mm);
				end else begin
					points_ok++;
				end
			end
		end
		if (hold_ask != hold_taken) begin
			hold_taken = hold_ask;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!idle_on) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (free_left > 0) begin
			free_left--;
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			free_left = $urandom_range(5, 60);
			out_stall <= 1'b0;
		end else begin
			stall_left = $urandom_range(0, 10);
			free_left = $urandom_range(1, 30);
			out_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d points pending",
				quiet_cycles, expected_pts.size());
			$display("lidar_polar_to_cartesian_tb failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_quadrant_edges();
		test_range_window();
		test_output_hold();
		test_random_scans(650);
		idle_on = 1'b0;
		test_random_scans(120);
		drain();
		bad_points += expected_pts.size();
		$display("ran %0d samples over %0d random scans plus directed cases", samples_sent,
			scans_run);
		$display("%0d points matched, %0d register writes, %0d bad points", points_ok,
			reg_writes, bad_points);
		if (bad_points == 0)
			$display("lidar_polar_to_cartesian_tb passed");
		else
			$display("lidar_polar_to_cartesian_tb failed");
		$finish;
	end

endmodule
